// ----- rtl/pip_pkg.sv -----
// Shared constants, command codes and controller/datapath types for the point-in-polygon block.
package pip_pkg;

    // Storage and field sizes.
    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 16;
    localparam int VIDX_BITS    = 6;
    localparam int CFG_BITS     = 7;
    localparam int MIN_VERTICES = 3;
    localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
    localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);

    // Arithmetic widths, all exact for any coordinate pattern.
    // Difference of two coordinates.
    localparam int DIFF_BITS    = COORD_BITS + 1;
    // Far x coordinate: maxx + 2*(maxx - minx) + 1.
    localparam int ORG_BITS     = COORD_BITS + 3;
    // Far x minus a coordinate.
    localparam int ODIFF_BITS   = COORD_BITS + 4;
    // Far y minus a coordinate (far y is the point y plus one).
    localparam int OYD_BITS     = COORD_BITS + 2;
    localparam int SPROD_BITS   = ODIFF_BITS + DIFF_BITS;
    localparam int SV_BITS      = SPROD_BITS + 1;
    localparam int TPPROD_BITS  = 2 * DIFF_BITS;
    localparam int TP_BITS      = TPPROD_BITS + 1;
    localparam int TOA_BITS     = DIFF_BITS + OYD_BITS;
    localparam int TOB_BITS     = DIFF_BITS + ODIFF_BITS;
    localparam int TO_BITS      = TOB_BITS + 1;

    // Input item kinds.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Purpose of a vertex read, carried along with the read data.
    typedef logic [1:0] tag_t;
    localparam tag_t TAG_MM_FIRST   = 2'd0;
    localparam tag_t TAG_MM         = 2'd1;
    localparam tag_t TAG_EDGE_FIRST = 2'd2;
    localparam tag_t TAG_EDGE       = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                 load_we;
        logic                 capture_point;
        logic                 rd_en;
        logic [ADDR_BITS-1:0] rd_addr;
        tag_t                 rd_tag;
        logic                 calc_origin;
        logic                 out_load;
    } pip_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic busy;
    } pip_status_t;

endpackage

// ----- rtl/pip_ctrl.sv -----
// Controller state machine: sequences vertex loads, the range scan, the edge walk and the result.
module pip_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [pip_pkg::CFG_BITS-1:0]  vertex_count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output pip_pkg::pip_cmd_t             cmd,
    input  pip_pkg::pip_status_t          status
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_WAIT   = 3'd2;
    localparam logic [2:0] S_ORIGIN = 3'd3;
    localparam logic [2:0] S_EDGE   = 3'd4;
    localparam logic [2:0] S_DRAIN  = 3'd5;

    logic [2:0]                     state_reg;
    logic [2:0]                     state_next;
    logic [pip_pkg::CNT_BITS-1:0]   cnt_reg;
    logic [pip_pkg::CNT_BITS-1:0]   cnt_next;
    logic [pip_pkg::CNT_BITS-1:0]   n_use;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           in_fire;
    logic                           slot_free;

    // Number of vertices in use, held to the supported range.
    always_comb
    begin
        if (int'(vertex_count) < pip_pkg::MIN_VERTICES)
        begin
            n_use = pip_pkg::CNT_BITS'(pip_pkg::MIN_VERTICES);
        end
        else if (int'(vertex_count) > pip_pkg::MAX_VERTICES)
        begin
            n_use = pip_pkg::CNT_BITS'(pip_pkg::MAX_VERTICES);
        end
        else
        begin
            n_use = pip_pkg::CNT_BITS'(vertex_count);
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    // Next state, read sequencing and the output beat.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (kind == pip_pkg::KIND_QUERY)
                    begin
                        cmd.capture_point = 1'b1;
                        cnt_next          = '0;
                        state_next        = S_SCAN;
                    end
                    else
                    begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = cnt_reg[pip_pkg::ADDR_BITS-1:0];
                cmd.rd_tag  = (cnt_reg == '0) ? pip_pkg::TAG_MM_FIRST : pip_pkg::TAG_MM;
                if (cnt_reg == n_use - pip_pkg::CNT_BITS'(1))
                begin
                    cnt_next   = '0;
                    state_next = S_WAIT;
                end
                else
                begin
                    cnt_next = cnt_reg + pip_pkg::CNT_BITS'(1);
                end
            end
            S_WAIT:
            begin
                // The last x value reaches the range registers here.
                state_next = S_ORIGIN;
            end
            S_ORIGIN:
            begin
                cmd.calc_origin = 1'b1;
                state_next      = S_EDGE;
            end
            S_EDGE:
            begin
                // Vertices 0 to n-1, then vertex 0 again to close the polygon.
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = (cnt_reg == n_use) ? '0 : cnt_reg[pip_pkg::ADDR_BITS-1:0];
                cmd.rd_tag  = (cnt_reg == '0) ? pip_pkg::TAG_EDGE_FIRST : pip_pkg::TAG_EDGE;
                if (cnt_reg == n_use)
                begin
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + pip_pkg::CNT_BITS'(1);
                end
            end
            S_DRAIN:
            begin
                if (!status.busy && slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_edge_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EDGE) |-> (cnt_reg <= n_use))
        else $error("edge walk counter ran past the vertex count");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!status.busy && (!out_valid_reg || out_ready)))
        else $error("result loaded over a waiting beat or before the pipeline drained");

    a_query_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (kind == pip_pkg::KIND_QUERY)) |=> (state_reg == S_SCAN))
        else $error("accepted query did not start the range scan");

    a_no_read_outside_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |=> !status.busy || $past(status.busy))
        else $error("pipeline became busy again while draining");
`endif

endmodule

// ----- rtl/pip_dpath.sv -----
// Datapath: vertex memory, x range, far point and the pipelined edge crossing tests.
module pip_dpath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pip_pkg::pip_cmd_t                     cmd,
    output pip_pkg::pip_status_t                  status,
    input  logic [pip_pkg::VIDX_BITS-1:0]         vertex_index,
    input  logic signed [pip_pkg::COORD_BITS-1:0] coord_x,
    input  logic signed [pip_pkg::COORD_BITS-1:0] coord_y,
    output logic                                  inside_res
);

    localparam int C = pip_pkg::COORD_BITS;

    // Vertex memory, x in the upper half and y in the lower half.
    logic [2*C-1:0] vmem [pip_pkg::MAX_VERTICES];
    logic [2*C-1:0] rd_data_reg;
    logic           rvalid_reg;
    pip_pkg::tag_t  rtag_reg;

    logic signed [C-1:0] vx;
    logic signed [C-1:0] vy;
    logic                is_edge_read;

    logic signed [C-1:0]                   px_reg;
    logic signed [C-1:0]                   py_reg;
    logic signed [C-1:0]                   minx_reg;
    logic signed [C-1:0]                   maxx_reg;
    logic signed [pip_pkg::ORG_BITS-1:0]   span;
    logic signed [pip_pkg::ORG_BITS-1:0]   ox_reg;
    logic signed [C-1:0]                   ax_reg;
    logic signed [C-1:0]                   ay_reg;

    // Stage 1: differences.
    logic                                  s1_valid_reg;
    logic                                  s1_first_reg;
    logic                                  s1_rng_reg;
    logic signed [pip_pkg::ODIFF_BITS-1:0] d_ox_reg;
    logic signed [pip_pkg::DIFF_BITS-1:0]  d_vy_reg;
    logic signed [pip_pkg::DIFF_BITS-1:0]  d_vx_reg;
    logic signed [pip_pkg::DIFF_BITS-1:0]  ex_reg;
    logic signed [pip_pkg::DIFF_BITS-1:0]  ey_reg;
    logic signed [pip_pkg::DIFF_BITS-1:0]  dpx_reg;
    logic signed [pip_pkg::DIFF_BITS-1:0]  dpy_reg;
    logic signed [pip_pkg::OYD_BITS-1:0]   doy_reg;
    logic signed [pip_pkg::ODIFF_BITS-1:0] dox2_reg;
    logic                                  x_ok;
    logic                                  y_ok;

    // Stage 2: products.
    logic                                   s2_valid_reg;
    logic                                   s2_first_reg;
    logic                                   s2_rng_reg;
    logic signed [pip_pkg::SPROD_BITS-1:0]  m0_reg;
    logic signed [pip_pkg::DIFF_BITS-1:0]   dvx2_reg;
    logic signed [pip_pkg::TPPROD_BITS-1:0] m1_reg;
    logic signed [pip_pkg::TPPROD_BITS-1:0] m2_reg;
    logic signed [pip_pkg::TOA_BITS-1:0]    m3_reg;
    logic signed [pip_pkg::TOB_BITS-1:0]    m4_reg;

    // Stage 3: orientation signs.
    logic signed [pip_pkg::SV_BITS-1:0] sv;
    logic signed [pip_pkg::TP_BITS-1:0] tp;
    logic signed [pip_pkg::TO_BITS-1:0] tq;
    logic s3_valid_reg;
    logic s3_first_reg;
    logic s3_rng_reg;
    logic sv_pos_reg;
    logic sv_neg_reg;
    logic tp_pos_reg;
    logic tp_neg_reg;
    logic tp_zero_reg;
    logic to_pos_reg;
    logic to_neg_reg;

    // Stage 4: tally.
    logic sa_pos_reg;
    logic sa_neg_reg;
    logic parity_reg;
    logic on_any_reg;
    logic crossing;
    logic result_reg;

    // Memory write on a load beat, registered read for the walks.
    always_ff @(posedge clk)
    begin
        if (cmd.load_we && (int'(vertex_index) < pip_pkg::MAX_VERTICES))
        begin
            vmem[pip_pkg::ADDR_BITS'(vertex_index)] <= {coord_x, coord_y};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= vmem[cmd.rd_addr];
        end
    end

    assign vx           = rd_data_reg[2*C-1:C];
    assign vy           = rd_data_reg[C-1:0];
    assign is_edge_read = rvalid_reg &&
                          ((rtag_reg == pip_pkg::TAG_EDGE_FIRST) ||
                           (rtag_reg == pip_pkg::TAG_EDGE));

    // Query point and x range.
    always_ff @(posedge clk)
    begin
        if (cmd.capture_point)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (rvalid_reg)
        begin
            unique case (rtag_reg)
                pip_pkg::TAG_MM_FIRST:
                begin
                    minx_reg <= vx;
                    maxx_reg <= vx;
                end
                pip_pkg::TAG_MM:
                begin
                    if (vx < minx_reg)
                    begin
                        minx_reg <= vx;
                    end
                    if (vx > maxx_reg)
                    begin
                        maxx_reg <= vx;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Far point x: maxx + 2*(maxx - minx) + 1.
    assign span = pip_pkg::ORG_BITS'(maxx_reg) - pip_pkg::ORG_BITS'(minx_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.calc_origin)
        begin
            ox_reg <= pip_pkg::ORG_BITS'(maxx_reg) + (span <<< 1) + pip_pkg::ORG_BITS'(1);
        end
    end

    // Stage 1: the previous vertex is the edge start, the current one the edge end.
    assign x_ok = !(((ax_reg > px_reg) && (vx > px_reg)) || ((ax_reg < px_reg) && (vx < px_reg)));
    assign y_ok = !(((ay_reg > py_reg) && (vy > py_reg)) || ((ay_reg < py_reg) && (vy < py_reg)));

    always_ff @(posedge clk)
    begin
        if (is_edge_read)
        begin
            ax_reg       <= vx;
            ay_reg       <= vy;
            s1_first_reg <= (rtag_reg == pip_pkg::TAG_EDGE_FIRST);
            s1_rng_reg   <= x_ok && y_ok;
            d_ox_reg     <= pip_pkg::ODIFF_BITS'(ox_reg) - pip_pkg::ODIFF_BITS'(px_reg);
            d_vy_reg     <= pip_pkg::DIFF_BITS'(vy) - pip_pkg::DIFF_BITS'(py_reg);
            d_vx_reg     <= pip_pkg::DIFF_BITS'(vx) - pip_pkg::DIFF_BITS'(px_reg);
            ex_reg       <= pip_pkg::DIFF_BITS'(vx) - pip_pkg::DIFF_BITS'(ax_reg);
            ey_reg       <= pip_pkg::DIFF_BITS'(vy) - pip_pkg::DIFF_BITS'(ay_reg);
            dpx_reg      <= pip_pkg::DIFF_BITS'(px_reg) - pip_pkg::DIFF_BITS'(ax_reg);
            dpy_reg      <= pip_pkg::DIFF_BITS'(py_reg) - pip_pkg::DIFF_BITS'(ay_reg);
            doy_reg      <= pip_pkg::OYD_BITS'(py_reg) - pip_pkg::OYD_BITS'(ay_reg)
                            + pip_pkg::OYD_BITS'(1);
            dox2_reg     <= pip_pkg::ODIFF_BITS'(ox_reg) - pip_pkg::ODIFF_BITS'(ax_reg);
        end
    end

    // Stage 2: one product per multiplier, each registered.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_first_reg <= s1_first_reg;
            s2_rng_reg   <= s1_rng_reg;
            m0_reg       <= pip_pkg::SPROD_BITS'(d_ox_reg) * pip_pkg::SPROD_BITS'(d_vy_reg);
            dvx2_reg     <= d_vx_reg;
            m1_reg       <= pip_pkg::TPPROD_BITS'(ex_reg) * pip_pkg::TPPROD_BITS'(dpy_reg);
            m2_reg       <= pip_pkg::TPPROD_BITS'(ey_reg) * pip_pkg::TPPROD_BITS'(dpx_reg);
            m3_reg       <= pip_pkg::TOA_BITS'(ex_reg) * pip_pkg::TOA_BITS'(doy_reg);
            m4_reg       <= pip_pkg::TOB_BITS'(ey_reg) * pip_pkg::TOB_BITS'(dox2_reg);
        end
    end

    // Stage 3: orientation values and their signs.
    // sv: side of the vertex against the ray; tp, tq: sides of point and far point
    // against the edge. tp of zero means the point is on the edge line.
    assign sv = pip_pkg::SV_BITS'(m0_reg) - pip_pkg::SV_BITS'(dvx2_reg);
    assign tp = pip_pkg::TP_BITS'(m1_reg) - pip_pkg::TP_BITS'(m2_reg);
    assign tq = pip_pkg::TO_BITS'(m3_reg) - pip_pkg::TO_BITS'(m4_reg);

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_first_reg <= s2_first_reg;
            s3_rng_reg   <= s2_rng_reg;
            sv_pos_reg   <= (sv > 0);
            sv_neg_reg   <= sv[pip_pkg::SV_BITS-1];
            tp_pos_reg   <= (tp > 0);
            tp_neg_reg   <= tp[pip_pkg::TP_BITS-1];
            tp_zero_reg  <= (tp == '0);
            to_pos_reg   <= (tq > 0);
            to_neg_reg   <= tq[pip_pkg::TO_BITS-1];
        end
    end

    // Stage 4: count proper crossings and note any on-edge hit.
    assign crossing = ((sa_pos_reg && sv_neg_reg) || (sa_neg_reg && sv_pos_reg)) &&
                      ((tp_pos_reg && to_neg_reg) || (tp_neg_reg && to_pos_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.calc_origin)
        begin
            parity_reg <= 1'b0;
            on_any_reg <= 1'b0;
        end
        else if (s3_valid_reg)
        begin
            if (!s3_first_reg)
            begin
                parity_reg <= parity_reg ^ crossing;
                on_any_reg <= on_any_reg | (tp_zero_reg && s3_rng_reg);
            end
        end
        if (s3_valid_reg)
        begin
            sa_pos_reg <= sv_pos_reg;
            sa_neg_reg <= sv_neg_reg;
        end
        if (cmd.out_load)
        begin
            result_reg <= on_any_reg | parity_reg;
        end
    end

    assign inside_res = result_reg;

    // Pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg   <= 1'b0;
            rtag_reg     <= pip_pkg::TAG_MM_FIRST;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg   <= cmd.rd_en;
            rtag_reg     <= cmd.rd_tag;
            s1_valid_reg <= is_edge_read;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    assign status.busy = rvalid_reg || s1_valid_reg || s2_valid_reg || s3_valid_reg;

endmodule

// ----- rtl/point_in_polygon_test.sv -----
// Top level of the point-in-polygon block: configuration register, controller and datapath.
//
//  Channel   Handshake                      Payload
//  -------   ----------------------------   -------------------------------------------
//  config    psel/penable/pwrite, pready=1   paddr, pwdata, prdata (vertex_count at 0)
//  input     in_valid / in_ready            kind, vertex_index, coord_x, coord_y
//  output    out_valid / out_ready          inside_res
//
//  A load beat yields no result.
//  A query makes two passes over the vertices (n in use, 3 to 64) through the single memory read
//  port: one pass over x for the range, one pass over the edges.
//  The next beat is taken as soon as the query result sits in the output register.
//  A stalled output only holds a finished query at its last step; loads still go through.
//  Reset clears the controller and sets vertex_count to 3; the vertex memory is not cleared.
module point_in_polygon_test (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  kind,
    input  logic [pip_pkg::VIDX_BITS-1:0]         vertex_index,
    input  logic signed [pip_pkg::COORD_BITS-1:0] coord_x,
    input  logic signed [pip_pkg::COORD_BITS-1:0] coord_y,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  inside_res
);

    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic [pip_pkg::CFG_BITS-1:0] VERTEX_COUNT_RESET = pip_pkg::CFG_BITS'(3);

    logic [pip_pkg::CFG_BITS-1:0] vertex_count_reg;
    logic                         cfg_write;
    pip_pkg::pip_cmd_t            cmd;
    pip_pkg::pip_status_t         status;

    // Configuration register, written in the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VERTEX_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            vertex_count_reg <= pwdata[pip_pkg::CFG_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? 32'(vertex_count_reg) : '0;

    pip_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .vertex_count (vertex_count_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cmd          (cmd),
        .status       (status)
    );

    pip_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .vertex_index (vertex_index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .inside_res   (inside_res)
    );

endmodule
